// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Shared assertion forms for the segmentation engine.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/gsuf_pkg.sv -----
`timescale 1ns / 1ps
package gsuf_pkg;
	localparam int VERTEX_COUNT = 4096;
	localparam logic [15:0] SCALE_K_RESET = 16'd300;
	localparam int FRAC_BITS = 7;
	localparam logic [12:0] SIZE_MAX = 13'd8191;
	localparam logic [3:0] RANK_MAX = 4'd15;
	localparam logic OP_MERGE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_RD_WALK,
		CMD_STEP_WALK,
		CMD_COMP_START,
		CMD_COMP_STEP,
		CMD_RD_ROOT,
		CMD_ROOTS,
		CMD_DIV_START,
		CMD_DIV_STEP,
		CMD_DIV_DONE,
		CMD_JOIN,
		CMD_RESULT
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic sel_b;
	} ctrl_t;

	typedef struct packed {
		logic clear_last;
		logic walk_done;
		logic comp_done;
		logic div_done;
		logic same_root;
		logic div_second;
		logic is_query;
	} stat_t;
endpackage

// ----- rtl/gsuf_if.sv -----
`timescale 1ns / 1ps
interface gsuf_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [11:0] vertex_a;
	logic [11:0] vertex_b;
	logic [15:0] edge_weight;
	modport source(output valid, opcode, vertex_a, vertex_b, edge_weight, input ready);
	modport sink(input valid, opcode, vertex_a, vertex_b, edge_weight, output ready);
endinterface

interface gsuf_out_if;
	logic valid;
	logic ready;
	logic merged;
	logic [11:0] root_label;
	logic [12:0] component_size;
	modport source(output valid, merged, root_label, component_size, input ready);
	modport sink(input valid, merged, root_label, component_size, output ready);
endinterface

// ----- rtl/gsuf_datapath.sv -----
`timescale 1ns / 1ps
module gsuf_datapath import gsuf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_t       ctrl,
	output stat_t       stat,
	input  logic        opcode,
	input  logic [11:0] vertex_a,
	input  logic [11:0] vertex_b,
	input  logic [15:0] edge_weight,
	input  logic [15:0] scale_k,
	output logic        merged,
	output logic [11:0] root_label,
	output logic [12:0] component_size
);
	localparam int AW = $clog2(VERTEX_COUNT);
	localparam int DW = 23;

	// Node record: parent, weight, size, rank.
	typedef struct packed {
		logic [AW-1:0] par;
		logic [15:0] wt;
		logic [12:0] sz;
		logic [3:0] rk;
	} node_t;

	node_t mem [VERTEX_COUNT];
	node_t rd_q;
	logic mem_we;
	logic [AW-1:0] wa, ra;
	node_t wd;

	logic [AW-1:0] clr_q, va_q, vb_q, cur_q, root_q, ra_q, rb_q;
	logic [15:0] w_q;
	logic op_q, sel_q, merged_q;
	node_t na_q, nb_q;
	logic [DW-1:0] rem_q, quo_q;
	logic [4:0] dcnt_q;
	logic [31:0] tha_q;
	logic second_q;
	logic [24:0] trial;

	// Join writeback registers.
	logic jw_q;
	node_t jk_q, jg_q;
	logic [AW-1:0] jka_q, jga_q;
	logic jphase_q;

	function automatic logic [AW-1:0] modv(input logic [11:0] v);
		logic [31:0] t;
		t = 32'(v) % VERTEX_COUNT;
		return t[AW-1:0];
	endfunction

	// One write port and one read port, registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	// Address and write selection.
	always_comb begin
		mem_we = 1'b0;
		wa = clr_q;
		wd = '{par: clr_q, wt: 16'd0, sz: 13'd1, rk: 4'd0};
		ra = cur_q;
		case (ctrl.cmd)
			CMD_CLEAR: mem_we = 1'b1;
			CMD_RD_WALK: ra = ctrl.sel_b ? vb_q : va_q;
			CMD_STEP_WALK: ra = rd_q.par;
			CMD_COMP_STEP: begin
				mem_we = 1'b1;
				wa = cur_q;
				wd = rd_q;
				wd.par = root_q;
				ra = rd_q.par;
			end
			CMD_RD_ROOT: ra = ra_q;
			CMD_JOIN: ;
			default: begin
				// The kept root is written first, then the absorbed root.
				if (jw_q) begin
					mem_we = 1'b1;
					wa = jka_q;
					wd = jk_q;
				end else if (jphase_q) begin
					mem_we = 1'b1;
					wa = jga_q;
					wd = '{par: jka_q, wt: jg_q.wt, sz: jg_q.sz, rk: jg_q.rk};
				end
			end
		endcase
	end

	assign trial = {rem_q, quo_q[DW-1]} - {12'd0, (second_q ? nb_q.sz : na_q.sz)};

	// Join evaluation.
	logic keep_b, rank_up, can_join;
	logic [13:0] sum;
	always_comb begin
		keep_b = !(na_q.rk > nb_q.rk);
		rank_up = (na_q.rk == nb_q.rk) && (nb_q.rk < RANK_MAX);
		sum = {1'b0, na_q.sz} + {1'b0, nb_q.sz};
		can_join = (32'(w_q) <= tha_q) &&
			(32'(w_q) <= 32'(nb_q.wt) + 32'(quo_q));
	end

	// Clear pass address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (ctrl.cmd == CMD_CLEAR) clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CMD_LOAD: begin
				va_q <= modv(vertex_a);
				vb_q <= modv(vertex_b);
				w_q <= edge_weight;
				op_q <= opcode;
				merged_q <= 1'b0;
				second_q <= 1'b0;
			end
			CMD_RD_WALK: begin
				sel_q <= ctrl.sel_b;
				cur_q <= ctrl.sel_b ? vb_q : va_q;
			end
			CMD_STEP_WALK: cur_q <= rd_q.par;
			CMD_COMP_START: begin
				root_q <= cur_q;
				cur_q <= sel_q ? vb_q : va_q;
				if (sel_q) rb_q <= cur_q; else ra_q <= cur_q;
			end
			CMD_COMP_STEP: cur_q <= rd_q.par;
			CMD_RD_ROOT: cur_q <= rb_q;
			CMD_ROOTS: na_q <= rd_q;
			CMD_DIV_START: begin
				if (ctrl.sel_b) nb_q <= rd_q;
				second_q <= ctrl.sel_b;
				rem_q <= '0;
				quo_q <= {scale_k, 7'd0};
				dcnt_q <= '0;
			end
			CMD_DIV_STEP: begin
				dcnt_q <= dcnt_q + 1'b1;
				if (!trial[24]) begin
					rem_q <= trial[DW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
			end
			// The first quotient gives the threshold of the first root.
			CMD_DIV_DONE: begin
				if (!second_q) begin
					tha_q <= 32'(na_q.wt) + 32'(quo_q);
					second_q <= 1'b1;
				end
			end
			CMD_JOIN: begin
				if (can_join) begin
					merged_q <= 1'b1;
					root_q <= keep_b ? rb_q : ra_q;
					ra_q <= keep_b ? rb_q : ra_q;
					na_q.sz <= (sum > 14'(SIZE_MAX)) ? SIZE_MAX : sum[12:0];
				end else begin
					na_q.sz <= na_q.sz;
				end
			end
			default: ;
		endcase
	end

	// Capture the two node records that a join rewrites.
	always_ff @(posedge clk) begin
		if (ctrl.cmd == CMD_JOIN && can_join) begin
			jw_q <= 1'b1;
			jka_q <= keep_b ? rb_q : ra_q;
			jga_q <= keep_b ? ra_q : rb_q;
			jk_q.par <= keep_b ? rb_q : ra_q;
			jk_q.wt <= w_q;
			jk_q.sz <= (sum > 14'(SIZE_MAX)) ? SIZE_MAX : sum[12:0];
			jk_q.rk <= keep_b ? nb_q.rk + (rank_up ? 4'd1 : 4'd0) : na_q.rk;
			jg_q <= keep_b ? na_q : nb_q;
		end else begin
			jw_q <= 1'b0;
		end
		jphase_q <= jw_q;
	end

	always_comb begin
		stat.clear_last = (clr_q == AW'(VERTEX_COUNT - 1));
		stat.walk_done = (rd_q.par == cur_q);
		stat.comp_done = (cur_q == root_q);
		stat.div_done = (dcnt_q == 5'(DW - 1));
		stat.same_root = (ra_q == rb_q);
		stat.div_second = second_q;
		stat.is_query = (op_q == OP_QUERY);
	end

	assign merged = merged_q;
	assign root_label = 12'(ra_q);
	assign component_size = na_q.sz;
endmodule

// ----- rtl/gsuf_ctrl.sv -----
`timescale 1ns / 1ps
module gsuf_ctrl import gsuf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready
);
	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_WALK, S_CSTART, S_COMP, S_RDROOT, S_ROOTS,
		S_DSTART, S_DIV, S_DDONE, S_JOIN, S_WB1, S_WB2, S_OUT
	} state_t;

	state_t state_q;
	logic sel_q, outv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sel_q <= 1'b0;
			outv_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: if (stat.clear_last) state_q <= S_IDLE;
				S_IDLE: if (in_valid) begin
					sel_q <= 1'b0;
					state_q <= S_RD;
				end
				S_RD: state_q <= S_WALK;
				S_WALK: if (stat.walk_done) state_q <= S_CSTART;
				S_CSTART: state_q <= S_COMP;
				S_COMP: if (stat.comp_done) begin
					if (!sel_q && !stat.is_query) begin
						sel_q <= 1'b1;
						state_q <= S_RD;
					end else begin
						state_q <= S_RDROOT;
					end
				end
				S_RDROOT: state_q <= S_ROOTS;
				S_ROOTS: state_q <= (stat.is_query || stat.same_root) ? S_OUT : S_DSTART;
				S_DSTART: state_q <= S_DIV;
				S_DIV: if (stat.div_done) state_q <= S_DDONE;
				S_DDONE: state_q <= stat.div_second ? S_JOIN : S_DSTART;
				S_JOIN: state_q <= S_WB1;
				S_WB1: state_q <= S_WB2;
				S_WB2: state_q <= S_OUT;
				S_OUT: begin
					outv_q <= 1'b1;
					if (outv_q && out_ready) begin
						outv_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctrl.sel_b = sel_q;
		ctrl.cmd = CMD_NONE;
		case (state_q)
			S_CLEAR: ctrl.cmd = CMD_CLEAR;
			S_IDLE: ctrl.cmd = in_valid ? CMD_LOAD : CMD_NONE;
			S_RD: ctrl.cmd = CMD_RD_WALK;
			S_WALK: ctrl.cmd = stat.walk_done ? CMD_COMP_START : CMD_STEP_WALK;
			S_COMP: ctrl.cmd = stat.comp_done ? CMD_NONE : CMD_COMP_STEP;
			S_RDROOT: ctrl.cmd = CMD_RD_ROOT;
			S_ROOTS: ctrl.cmd = CMD_ROOTS;
			S_DSTART: ctrl.cmd = CMD_DIV_START;
			S_DIV: ctrl.cmd = CMD_DIV_STEP;
			S_DDONE: ctrl.cmd = CMD_DIV_DONE;
			S_JOIN: ctrl.cmd = CMD_JOIN;
			S_OUT: ctrl.cmd = CMD_RESULT;
			default: ctrl.cmd = CMD_NONE;
		endcase
		// The second division works on the root of vertex_b.
		if (state_q == S_DSTART) ctrl.sel_b = stat.div_second;
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = outv_q;

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, out_valid, !in_ready, "input taken while result waits")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`ASSERT_NEXT(a_load_walk, clk, arst_n, in_valid && in_ready, state_q == S_RD, "load did not start walk")
endmodule

// ----- rtl/graph_segment_union_find.sv -----
`timescale 1ns / 1ps
// From acceptance to result valid, each walked vertex is read, walked to its root and compressed.
// An edge between two different roots adds two divisions, the join and two writes.
// One transaction at a time; the next is taken in the cycle after the result leaves.
// Reset: arst_n clears control at once, then a clear pass reinitializes every node of the
// node memory while no transaction is taken. scale_k resets to 300.
module graph_segment_union_find import gsuf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	gsuf_in_if.sink       in_ch,
	gsuf_out_if.source    out_ch
);
	ctrl_t ctrl;
	stat_t stat;
	logic [15:0] scale_k_q;

	// Scale register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scale_k_q <= SCALE_K_RESET;
		else if (cfg_we) scale_k_q <= cfg_wdata;
	end

	gsuf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .stat(stat), .ctrl(ctrl),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready)
	);

	gsuf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.opcode(in_ch.opcode), .vertex_a(in_ch.vertex_a), .vertex_b(in_ch.vertex_b),
		.edge_weight(in_ch.edge_weight), .scale_k(scale_k_q),
		.merged(out_ch.merged), .root_label(out_ch.root_label),
		.component_size(out_ch.component_size)
	);
endmodule
